>>> hw/rtl/mouse_report_accumulator_i2c_assert.svh
// Assertion macros used by the checker of this block.
// Both expect clk and rst_n in scope.
`ifndef MOUSE_REPORT_ACCUMULATOR_I2C_ASSERT_SVH
`define MOUSE_REPORT_ACCUMULATOR_I2C_ASSERT_SVH

// same-cycle implication
`define MRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mra_pkg.sv
package mra_pkg;

  // item kinds
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_CMD    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [7:0] CMD_GET_CAPS = 8'hFF;
  localparam logic [2:0] CAPS_RESET   = 3'd5;

  // report mask bits
  localparam int MASK_XY       = 0;
  localparam int MASK_PRESSURE = 1;
  localparam int MASK_BUTTONS  = 2;

  // button_bits layout
  localparam int BTN_SCROLL_UP   = 3;
  localparam int BTN_SCROLL_DOWN = 4;

  // response byte slots, in send order
  localparam int NUM_STEPS = 9;
  localparam int STEP_W    = 4;
  localparam logic [STEP_W-1:0] STEP_MASK = 4'd0;
  localparam logic [STEP_W-1:0] STEP_XL   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_XH   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_YL   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_YH   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_P0   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_P1   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_B0   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd8;

  // job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] dx_move;
    logic signed [15:0] dy_move;
    logic signed [7:0]  wheel_move;
    logic               left_pressed;
    logic               right_pressed;
    logic               middle_pressed;
    logic [7:0]         command_byte;
  } mra_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       last_byte;
  } mra_out_t;

  // snapshot of state taken when a read is accepted
  typedef struct packed {
    logic        caps_mode;
    logic [2:0]  caps;
    logic [2:0]  mask;
    logic [15:0] x_total;
    logic [15:0] y_total;
    logic [4:0]  buttons;
  } mra_job_t;

  typedef struct packed {
    logic     push;
    mra_job_t job;
  } mra_push_t;

  typedef struct packed {
    logic     full;
    logic     empty;
    mra_job_t head;
  } mra_qstat_t;

endpackage

>>> hw/rtl/mouse_report_accumulator_i2c.sv
// Mouse report accumulator behind a bus target. Input words are reports
// (func 0: add dx/dy into wrapping 16-bit totals, latch buttons, set sticky
// scroll bits), commands (func 1: 0xFF selects a capabilities read, anything
// else sets the report mask to command AND capabilities) and read requests
// (func 2: emit the response bytes, last_byte marking the final one). Func 3
// is dropped. Reports and commands, like reads, wait while the job queue is
// full.
// A read is snapshotted into a two-entry job queue when accepted, so the
// input side keeps taking words while the back end streams bytes; the output
// sends one byte per cycle from a registered slot while out_stall is low, so a
// read gives 1 to 9 bytes (mask, 4 xy, 2 pressure and 2 button bytes).
// in_stall rises only while both queue entries hold unsent reads.
// The capabilities register sits at byte address 0 of the APB port; any
// address with paddr[2] clear hits it, and reads return it zero-extended.
module mouse_report_accumulator_i2c import mra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mra_in_t               in_word,
  // response bytes
  output logic                  out_valid,
  input  logic                  out_stall,
  output mra_out_t              out_word,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [2:0] caps_r;
  logic       cfg_wr;
  logic       pop;
  mra_push_t  push;
  mra_qstat_t qstat;

  // capabilities register; no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : {{(CFG_DATA_W-3){1'b0}}, caps_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r <= CAPS_RESET;
    end else if (cfg_wr) begin
      caps_r <= pwdata[2:0];
    end
  end

  // front: classify words, update totals, snapshot reads
  mra_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .caps     (caps_r),
    .q_full   (qstat.full),
    .push     (push)
  );

  // pending read snapshots
  mra_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (qstat)
  );

  // back: serialize one snapshot into response bytes
  mra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> hw/rtl/mra_front.sv
module mra_front import mra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mra_in_t    in_word,
  input  logic [2:0] caps,
  input  logic       q_full,
  output mra_push_t  push
);

  logic [15:0] x_total_r, x_total_nxt;
  logic [15:0] y_total_r, y_total_nxt;
  logic [4:0]  button_bits_r, button_bits_nxt;
  logic [2:0]  report_mask_r, report_mask_nxt;
  logic        caps_mode_r, caps_mode_nxt;
  logic        accept;
  logic        scroll_up;
  logic        scroll_down;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign scroll_up   = (in_word.wheel_move != 8'sd0) && !in_word.wheel_move[7];
  assign scroll_down = in_word.wheel_move[7];

  always_comb begin
    x_total_nxt     = x_total_r;
    y_total_nxt     = y_total_r;
    button_bits_nxt = button_bits_r;
    report_mask_nxt = report_mask_r;
    caps_mode_nxt   = caps_mode_r;
    push.push       = 1'b0;
    push.job        = '{caps_mode: caps_mode_r, caps: caps, mask: report_mask_r,
                        x_total: x_total_r, y_total: y_total_r,
                        buttons: button_bits_r};
    if (accept) begin
      unique case (in_word.func)
        FUNC_REPORT: begin
          x_total_nxt = x_total_r + $unsigned(in_word.dx_move);
          y_total_nxt = y_total_r + $unsigned(in_word.dy_move);
          button_bits_nxt = {button_bits_r[BTN_SCROLL_DOWN] | scroll_down,
                             button_bits_r[BTN_SCROLL_UP] | scroll_up,
                             in_word.middle_pressed, in_word.right_pressed,
                             in_word.left_pressed};
        end
        FUNC_CMD: begin
          if (in_word.command_byte == CMD_GET_CAPS) begin
            caps_mode_nxt = 1'b1;
          end else begin
            caps_mode_nxt   = 1'b0;
            report_mask_nxt = in_word.command_byte[2:0] & caps;
          end
        end
        FUNC_READ: begin
          push.push = 1'b1;
          // reading clears what was sent
          if (!caps_mode_r) begin
            if (report_mask_r[MASK_XY]) begin
              x_total_nxt = '0;
              y_total_nxt = '0;
            end
            if (report_mask_r[MASK_BUTTONS]) begin
              button_bits_nxt[BTN_SCROLL_UP]   = 1'b0;
              button_bits_nxt[BTN_SCROLL_DOWN] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_total_r     <= '0;
      y_total_r     <= '0;
      button_bits_r <= '0;
      report_mask_r <= CAPS_RESET;
      caps_mode_r   <= 1'b0;
    end else begin
      x_total_r     <= x_total_nxt;
      y_total_r     <= y_total_nxt;
      button_bits_r <= button_bits_nxt;
      report_mask_r <= report_mask_nxt;
      caps_mode_r   <= caps_mode_nxt;
    end
  end

endmodule

>>> hw/rtl/mra_queue.sv
module mra_queue import mra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mra_push_t  push,
  input  logic       pop,
  output mra_qstat_t stat
);

  mra_job_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign do_push = push.push && (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/mra_back.sv
module mra_back import mra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mra_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output mra_out_t   out_word
);

  logic [STEP_W-1:0]    step_r;
  logic [STEP_W-1:0]    next_step;
  logic                 out_valid_r;
  mra_out_t             out_word_r;
  logic [NUM_STEPS-1:0] enabled;
  logic [NUM_STEPS-1:0] later;
  logic [7:0]           cur_byte;
  logic                 is_last;
  logic                 load;
  mra_job_t             job;

  assign job = qstat.head;

  // slots sent for this job
  always_comb begin
    if (job.caps_mode) begin
      enabled = NUM_STEPS'(1);
    end else begin
      enabled = {{2{job.mask[MASK_BUTTONS]}}, {2{job.mask[MASK_PRESSURE]}},
                 {4{job.mask[MASK_XY]}}, 1'b1};
    end
  end

  // slots still to go after this one
  assign later   = enabled & ~((NUM_STEPS'(2) << step_r) - NUM_STEPS'(1));
  assign is_last = (later == '0);

  always_comb begin
    next_step = STEP_MASK;
    for (int i = NUM_STEPS - 1; i >= 0; i--) begin
      if (later[i]) next_step = STEP_W'(i);
    end
  end

  always_comb begin
    case (step_r)
      STEP_MASK: cur_byte = {5'b0, (job.caps_mode ? job.caps : job.mask)};
      STEP_XL:   cur_byte = job.x_total[7:0];
      STEP_XH:   cur_byte = job.x_total[15:8];
      STEP_YL:   cur_byte = job.y_total[7:0];
      STEP_YH:   cur_byte = job.y_total[15:8];
      STEP_B0:   cur_byte = {3'b0, job.buttons};
      default:   cur_byte = 8'h00; // pressure bytes and button high byte
    endcase
  end

  assign load = !qstat.empty && (!out_valid_r || !out_stall);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= '{read_byte: cur_byte, last_byte: is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= STEP_MASK;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= is_last ? STEP_MASK : next_step;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> hw/rtl/mra_checker.sv
`include "mouse_report_accumulator_i2c_assert.svh"

module mra_checker import mra_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input mra_out_t              out_word,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic                  pready,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata
);

  `MRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")

  // a response streams without gaps until its last byte
  `MRA_ASSERT_NEXT(a_resp_gapless, out_valid && !out_stall && !out_word.last_byte, out_valid, "gap inside a response")

  `MRA_ASSERT_NEXT(a_caps_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[2:0] == $past(pwdata[2:0])), "capabilities readback mismatch")

  `MRA_ASSERT_NOW(a_resp_first_byte, out_valid && $past(out_valid && !out_stall && out_word.last_byte), out_word.read_byte[7:3] == 5'b0, "response does not open with a mask byte")

endmodule

bind mouse_report_accumulator_i2c mra_checker u_chk (.*);
